@@ rtl/lph_pkg.sv @@
// Shared types and constants for the linear-probe hash table.
`default_nettype none
package lph_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int KIND_W    = 2;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int STATUS_W  = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// one table slot as stored in memory
	typedef struct packed {
		logic             used;
		logic             deleted;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	// controller -> datapath
	typedef struct packed {
		logic load;         // capture request fields
		logic clr_step;     // clear slot at sweep address, advance
		logic probe_start;  // load home slot, reset probe counter
		logic probe;        // probe phase: issue reads, evaluate slots
		logic out_load;     // move result into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;     // sweep address is the last slot
		logic probe_done;   // request resolved this cycle
	} dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/lph_mod.sv @@
// Home slot unit: key modulo slot count, by a mask or by a reciprocal multiply.
`default_nettype none
module lph_mod #(
	parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lph_pkg::KEY_W-1:0]  key,
	output logic                            done,
	output logic [$clog2(SLOTS)-1:0]        home
);
	import lph_pkg::*;

	localparam int IDXW     = $clog2(SLOTS);
	localparam bit IS_POW2  = ((1 << IDXW) == SLOTS);

	generate
		if (IS_POW2) begin : g_pow2
			logic            done_q;
			logic [IDXW-1:0] home_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= key[IDXW-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_recip
			// exact division by the constant SLOTS: multiply-high, fix-up add, shift;
			// remainder = key - quotient * SLOTS
			localparam logic [63:0] M_FULL =
				((((64'd1 << IDXW) - 64'(SLOTS)) << KEY_W) / 64'(SLOTS)) + 64'd1;
			localparam logic [KEY_W-1:0] M_LO = KEY_W'(M_FULL);

			logic               vld_s1;
			logic               vld_s2;
			logic               done_q;
			logic [KEY_W-1:0]   key_s1;
			logic [KEY_W-1:0]   mulhi_s1;
			logic [KEY_W-1:0]   key_s2;
			logic [KEY_W-1:0]   quo_s2;
			logic [IDXW-1:0]    home_q;
			logic [2*KEY_W-1:0] prod;
			logic [KEY_W-1:0]   quo;
			logic [KEY_W-1:0]   rem;

			// t1 + (n - t1) / 2 never exceeds the key, so 32 bits hold it
			always_comb begin
				prod = (2*KEY_W)'(key) * (2*KEY_W)'(M_LO);
				quo  = (mulhi_s1 + ((key_s1 - mulhi_s1) >> 1)) >> (IDXW - 1);
				rem  = key_s2 - KEY_W'(quo_s2 * KEY_W'(SLOTS));
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					vld_s1 <= start;
					vld_s2 <= vld_s1;
					done_q <= vld_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_s1   <= key;
					mulhi_s1 <= prod[2*KEY_W-1:KEY_W];
				end
				if (vld_s1) begin
					key_s2 <= key_s1;
					quo_s2 <= quo;
				end
				if (vld_s2) begin
					home_q <= rem[IDXW-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end
	endgenerate

endmodule
`default_nettype wire

@@ rtl/lph_datapath.sv @@
// Datapath: slot memory, probe address/counter, slot evaluation, result registers.
`default_nettype none
module lph_datapath #(
	parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lph_pkg::dp_cmd_t              cmd,
	output lph_pkg::dp_sts_t                   sts,
	input  wire logic [lph_pkg::KIND_W-1:0]    kind,
	input  wire logic [lph_pkg::KEY_W-1:0]     key,
	input  wire logic [lph_pkg::VAL_W-1:0]     value,
	input  wire logic [$clog2(SLOTS)-1:0]      home,
	output logic [lph_pkg::STATUS_W-1:0]       status,
	output logic [lph_pkg::VAL_W-1:0]          found_value
);
	import lph_pkg::*;

	localparam int IDXW = $clog2(SLOTS);
	localparam int CNTW = $clog2(SLOTS + 1);

	slot_t mem [SLOTS];

	logic [KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	logic [IDXW-1:0]     idx_q;
	logic [IDXW-1:0]     idx_inc;
	logic [CNTW-1:0]     cnt_q;
	logic                issue;

	logic                rd_vld_s1;
	logic                rd_last_s1;
	logic [IDXW-1:0]     rd_idx_s1;
	slot_t               rdata_s1;

	logic                wr_en;
	logic [IDXW-1:0]     wr_addr;
	slot_t               wr_data;
	logic                done;
	logic [STATUS_W-1:0] res_st;
	logic [VAL_W-1:0]    res_val;
	logic [STATUS_W-1:0] res_status_q;
	logic [VAL_W-1:0]    res_found_q;
	logic [STATUS_W-1:0] status_q;
	logic [VAL_W-1:0]    found_value_q;

	assign idx_inc = (idx_q == IDXW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign issue   = cmd.probe && (cnt_q < CNTW'(SLOTS));

	// evaluate the slot read last cycle; decide hit, stop or keep going
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_idx_s1;
		wr_data = '0;
		done    = 1'b0;
		res_st  = ST_MISSING;
		res_val = '0;
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
		end else if (cmd.probe) begin
			case (kind_q)
				KIND_INSERT: begin
					if (rd_vld_s1) begin
						if (!rdata_s1.used || rdata_s1.deleted) begin
							wr_en           = 1'b1;
							wr_data.used    = 1'b1;
							wr_data.deleted = 1'b0;
							wr_data.key     = key_q;
							wr_data.value   = value_q;
							done            = 1'b1;
							res_st          = ST_OK;
						end else if (rd_last_s1) begin
							done   = 1'b1;
							res_st = ST_FULL;
						end
					end
				end
				KIND_DELETE, KIND_FIND: begin
					if (rd_vld_s1) begin
						if (!rdata_s1.used) begin
							done = 1'b1;
						end else if (!rdata_s1.deleted && rdata_s1.key == key_q) begin
							done   = 1'b1;
							res_st = ST_OK;
							if (kind_q == KIND_DELETE) begin
								wr_en           = 1'b1;
								wr_data         = rdata_s1;
								wr_data.deleted = 1'b1;
							end else begin
								res_val = rdata_s1.value;
							end
						end else if (rd_last_s1) begin
							done = 1'b1;
						end
					end
				end
				default: begin
					// undefined kind: report missing at once
					done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				idx_q <= idx_inc;
			end else if (cmd.probe_start) begin
				idx_q     <= home;
				cnt_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_inc;
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
		end
		if (issue) begin
			rd_idx_s1  <= idx_q;
			rd_last_s1 <= (cnt_q == CNTW'(SLOTS - 1));
		end
		if (done) begin
			res_status_q <= res_st;
			res_found_q  <= res_val;
		end
		if (cmd.out_load) begin
			status_q      <= res_status_q;
			found_value_q <= res_found_q;
		end
	end

	assign sts.clr_last   = (idx_q == IDXW'(SLOTS - 1));
	assign sts.probe_done = done;
	assign status         = status_q;
	assign found_value    = found_value_q;

endmodule
`default_nettype wire

@@ rtl/lph_ctrl.sv @@
// Controller: sequences clear sweep, home slot, probing and result delivery.
`default_nettype none
module lph_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic             mod_done,
	input  wire lph_pkg::dp_sts_t sts,
	output lph_pkg::dp_cmd_t      cmd
);
	import lph_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_PROBE,
		S_DELIVER
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR:   cmd.clr_step    = 1'b1;
			S_IDLE:    cmd.load        = in_valid;
			S_HOME:    cmd.probe_start = mod_done;
			S_PROBE:   cmd.probe       = 1'b1;
			S_DELIVER: cmd.out_load    = out_free;
			default:   cmd             = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_HOME;
				end
				S_HOME: begin
					if (mod_done) state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (sts.probe_done) state_q <= S_DELIVER;
				end
				S_DELIVER: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/linear_probe_hash_table_core.sv @@
// Top level of the linear-probe hash table: controller, datapath and home slot unit.
`default_nettype none
// Probing: a request settles after 1 to SLOTS probes (none for an undefined kind); probes
//   run one slot per cycle on the slot memory's single read port. A SLOTS that is not a
//   power of two takes key mod SLOTS from a pipelined reciprocal multiply, not a mask.
// Flow: one request at a time; the next one is taken once the result sits in the output
//   register, which may still wait for out_ready.
// Reset: after arst_n a clearing pass writes every slot empty while in_ready is low.
module linear_probe_hash_table_core #(
	parameter int SLOTS = lph_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lph_pkg::KIND_W-1:0]    kind,
	input  wire logic [lph_pkg::KEY_W-1:0]     key,
	input  wire logic [lph_pkg::VAL_W-1:0]     value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [lph_pkg::STATUS_W-1:0]       status,
	output logic [lph_pkg::VAL_W-1:0]          found_value
);
	import lph_pkg::*;

	localparam int IDXW = $clog2(SLOTS);

	dp_cmd_t         cmd;
	dp_sts_t         sts;
	logic            mod_done;
	logic [IDXW-1:0] home;

	// controller: clear sweep, request capture, probe phase, result hand-off
	lph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mod_done  (mod_done),
		.sts       (sts),
		.cmd       (cmd)
	);

	// home slot = key mod SLOTS, started as the request is captured
	lph_mod #(
		.SLOTS (SLOTS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load),
		.key    (key),
		.done   (mod_done),
		.home   (home)
	);

	// slot memory and probe logic; reads are pipelined one slot ahead of evaluation
	lph_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.home        (home),
		.status      (status),
		.found_value (found_value)
	);

endmodule
`default_nettype wire

@@ tb/linear_probe_hash_table_core_tb.sv @@
// Testbench for the linear-probe hash table core: self-checking, with its own table predictor.
`timescale 1ns / 1ps
module linear_probe_hash_table_core_tb;
	import lph_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	// kind 3 is not a defined operation; the block must treat it as a miss
	localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;
	// longest quiet stretch: reset clearing pass or a full-table scan, plus a long
	// output stall, taken several times over
	localparam int WATCHDOG_LIMIT = 4000;
	// drain after the last result: worst-case probe latency with margin
	localparam int END_DRAIN = 400;
	localparam int RANDOM_REQUESTS = 230;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    found_value;
	} lookup_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind = '0;
	logic [KEY_W-1:0]    key = '0;
	logic [VAL_W-1:0]    value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    found_value;

	// shadow copy of the slot table
	bit             shadow_used    [SLOTS];
	bit             shadow_deleted [SLOTS];
	bit [KEY_W-1:0] shadow_key     [SLOTS];
	bit [VAL_W-1:0] shadow_value   [SLOTS];

	lookup_result_t pending_results[$];
	logic [KEY_W-1:0] recent_keys[$];

	int errors = 0;
	int idle_cycles = 0;
	int results_checked = 0;
	int burst_left = 0;
	int n_insert = 0, n_delete = 0, n_find = 0, n_undef = 0;
	int n_full = 0, n_hit = 0, n_miss = 0;

	// receiver stall pattern state
	int rx_mode = 0, rx_seg_left = 0, rx_hold_left = 0;

	linear_probe_hash_table_core #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found_value(found_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow table and return what the block must answer.
	function automatic lookup_result_t table_apply(input logic [KIND_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		lookup_result_t res;
		int unsigned idx;
		int n;
		bit done;
		bit hit;
		res.status = ST_MISSING;
		res.found_value = '0;
		idx = k % SLOTS;
		done = 1'b0;
		hit = 1'b0;
		if (op == KIND_INSERT) begin
			n_insert++;
			res.status = ST_FULL;
			// first unused slot or tombstone along the probe path
			for (n = 0; n < SLOTS && !done; n++) begin
				if (!shadow_used[idx] || shadow_deleted[idx]) begin
					shadow_used[idx] = 1'b1;
					shadow_deleted[idx] = 1'b0;
					shadow_key[idx] = k;
					shadow_value[idx] = v;
					res.status = ST_OK;
					done = 1'b1;
				end else begin
					idx = (idx + 1) % SLOTS;
				end
			end
			if (res.status == ST_FULL)
				n_full++;
		end else if (op == KIND_DELETE || op == KIND_FIND) begin
			if (op == KIND_DELETE)
				n_delete++;
			else
				n_find++;
			// stop at an unused slot; skip tombstones; match live slots only
			for (n = 0; n < SLOTS && !done; n++) begin
				if (!shadow_used[idx]) begin
					done = 1'b1;
				end else if (!shadow_deleted[idx] && shadow_key[idx] == k) begin
					hit = 1'b1;
					done = 1'b1;
				end else begin
					idx = (idx + 1) % SLOTS;
				end
			end
			if (hit) begin
				res.status = ST_OK;
				n_hit++;
				if (op == KIND_DELETE)
					shadow_deleted[idx] = 1'b1;
				else
					res.found_value = shadow_value[idx];
			end else begin
				n_miss++;
			end
		end else begin
			n_undef++;
		end
		return res;
	endfunction

	// Send one request. Called at a rising edge; returns at the edge that accepted it,
	// leaving in_valid high so a back-to-back request needs no second assignment.
	task automatic send_request(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 10);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		key <= k;
		value <= v;
		// inputs only move at rising edges, so ready seen at the falling edge holds
		// at the next rising edge
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		pending_results.push_back(table_apply(op, k, v));
	endtask

	// Edge cases: empty-table lookups of key 0, duplicates, tombstones, wrap-around,
	// undefined kind.
	task automatic test_directed();
		send_request(KIND_FIND,   32'h0000_0000, 32'h0);
		send_request(KIND_DELETE, 32'h0000_0000, 32'h0);
		send_request(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
		send_request(KIND_FIND,   32'h0000_0000, 32'h0);
		send_request(KIND_INSERT, 32'h0000_0000, 32'hA5A5_0001); // duplicate copy
		send_request(KIND_FIND,   32'h0000_0000, 32'h0);         // first copy wins
		send_request(KIND_DELETE, 32'h0000_0000, 32'h0);
		send_request(KIND_FIND,   32'h0000_0000, 32'h0);         // past the tombstone
		send_request(KIND_INSERT, 32'h0000_0100, 32'h0000_1111); // reuses tombstone
		send_request(KIND_FIND,   32'h0000_0100, 32'h0);
		send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // last slot
		send_request(KIND_INSERT, 32'h0000_01FF, 32'h0000_0022); // wraps past last slot
		send_request(KIND_FIND,   32'h0000_01FF, 32'h0);
		send_request(KIND_FIND,   32'hFFFF_FFFF, 32'h0);
		send_request(KIND_DELETE, 32'hFFFF_FFFF, 32'h0);
		send_request(KIND_FIND,   32'h0000_01FF, 32'h0);
		send_request(KIND_DELETE, 32'h1234_5678, 32'h0);         // absent key
		send_request(KIND_UNDEF,  32'h0000_0000, 32'h0);
		send_request(KIND_UNDEF,  32'h0000_01FF, 32'hFFFF_FFFF);
		send_request(KIND_FIND,   32'hFFFF_FFFF, 32'h0);
		send_request(KIND_INSERT, 32'h8000_0080, 32'h0000_0000);
		send_request(KIND_FIND,   32'h0000_0080, 32'h0);         // same home, other key
		send_request(KIND_DELETE, 32'h8000_0080, 32'h0);
		send_request(KIND_INSERT, 32'h0000_0080, 32'hDEAD_BEEF);
		send_request(KIND_FIND,   32'h0000_0080, 32'h0);
	endtask

	// Mixed traffic; most keys are recently inserted ones or share a few home slots,
	// so hits, collisions and tombstone reuse are common.
	task automatic test_random_mix();
		int i;
		int sel;
		logic [KIND_W-1:0] op;
		logic [KEY_W-1:0] k;
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35)
				op = KIND_INSERT;
			else if (sel < 60)
				op = KIND_DELETE;
			else if (sel < 95)
				op = KIND_FIND;
			else
				op = KIND_UNDEF;
			sel = $urandom_range(0, 99);
			if (sel < 55 && recent_keys.size() > 0)
				k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			else if (sel < 80)
				k = ($urandom & ~32'hFF) | $urandom_range(0, 7); // clustered homes
			else
				k = $urandom;
			if (op == KIND_INSERT) begin
				recent_keys.push_back(k);
				if (recent_keys.size() > 48)
					void'(recent_keys.pop_front());
			end
			send_request(op, k, $urandom);
		end
	endtask

	// Fill every free slot, then hit the full table, full-length scans and scans
	// through tombstones with no unused slot to stop them.
	task automatic test_full_table();
		int i;
		int free_slots;
		logic [KEY_W-1:0] fill_keys[$];
		logic [KEY_W-1:0] k;
		free_slots = 0;
		for (i = 0; i < SLOTS; i++)
			if (!shadow_used[i] || shadow_deleted[i])
				free_slots++;
		repeat (free_slots) begin
			k = $urandom;
			fill_keys.push_back(k);
			send_request(KIND_INSERT, k, $urandom);
		end
		send_request(KIND_INSERT, $urandom, $urandom);      // table full
		send_request(KIND_FIND, $urandom, 32'h0);           // scans every slot
		send_request(KIND_UNDEF, $urandom, $urandom);
		for (i = 0; i < 4; i++)
			send_request(KIND_DELETE, fill_keys[i], 32'h0);
		send_request(KIND_FIND, $urandom, 32'h0);           // loops over tombstones
		send_request(KIND_DELETE, $urandom, 32'h0);
		send_request(KIND_FIND, fill_keys[4], 32'h0);
		send_request(KIND_INSERT, fill_keys[0], 32'h5A5A_5A5A); // reuses a tombstone
		send_request(KIND_FIND, fill_keys[0], 32'h0);
		send_request(KIND_INSERT, $urandom, $urandom);
		send_request(KIND_INSERT, $urandom, $urandom);
		send_request(KIND_INSERT, $urandom, $urandom);
		send_request(KIND_INSERT, $urandom, $urandom);      // full again
	endtask

	// Receiver: segments of always-ready, coin-flip ready, and occasional long holds.
	always @(posedge clk) begin
		if (rx_seg_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_seg_left = $urandom_range(20, 120);
		end else begin
			rx_seg_left--;
		end
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= $urandom_range(0, 1);
			end
			default: begin
				if (rx_hold_left > 0) begin
					rx_hold_left--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_hold_left = $urandom_range(1, 30);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// Result check and watchdog. Sampled at the falling edge: a handshake seen here
	// completes at the next rising edge.
	always @(negedge clk) begin
		lookup_result_t exp_res;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, status %0d found_value %h",
						$time, status, found_value);
				end else begin
					exp_res = pending_results.pop_front();
					if (status !== exp_res.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, exp_res.status, status);
					end
					if (found_value !== exp_res.found_value) begin
						errors++;
						$display("%0t: found_value mismatch, expected %h, actual %h",
							$time, exp_res.found_value, found_value);
					end
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int i;
		for (i = 0; i < SLOTS; i++) begin
			shadow_used[i] = 1'b0;
			shadow_deleted[i] = 1'b0;
			shadow_key[i] = '0;
			shadow_value[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// in_ready stays low through the clearing pass; send_request waits on it

		test_directed();
		test_random_mix();
		test_full_table();
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);
		if (pending_results.size() != 0)
			errors++;

		$display("Sent %0d inserts (%0d to a full table), %0d deletes, %0d finds, %0d undefined",
			n_insert, n_full, n_delete, n_find, n_undef);
		$display("Checked %0d results; lookups gave %0d hits and %0d misses",
			results_checked, n_hit, n_miss);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
